// File: rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types, constants and the CRC-16 byte update for the frame deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  // Byte counter width; the counter saturates at its all-ones value.
  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Frame overhead: header (6), HCS (2), FCS (2) and end byte (1).
  localparam int FRAME_OVERHEAD = 11;
  localparam int PAYLOAD_START  = 8;

  localparam logic [7:0] START_BYTE_RST = 8'h68;
  localparam logic [7:0] END_BYTE_RST   = 8'h16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 1'b1;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Error flag bit positions.
  localparam int ERR_START = 0;
  localparam int ERR_HCS   = 1;
  localparam int ERR_FCS   = 2;
  localparam int ERR_END   = 3;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FRAME = 3'd1,
    ST_HCS   = 3'd2,
    ST_FCS   = 3'd3,
    ST_END   = 3'd4
  } status_t;

  // One queue entry: the results caused by one accepted byte.
  typedef struct packed {
    logic        pay_v;
    logic        stat_v;
    logic [7:0]  pay_byte;
    status_t     status;
    logic [15:0] length;
    logic [7:0]  control;
    logic [7:0]  address;
  } mfd_entry_t;

  typedef struct packed {
    logic       push;
    mfd_entry_t entry;
  } mfd_qwr_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    mfd_entry_t entry;
  } mfd_qrd_t;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // CRC-16, MSB first, one byte per call.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/mfd_in_if.sv
// ----------------------------------------------------------------------------
// mfd_in_if
// Byte channel into the deframer: one buffer byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface mfd_in_if import mfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;

  modport source (output valid, output rx_byte, output buffer_end, input ready);
  modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

// File: rtl/mfd_out_if.sv
// ----------------------------------------------------------------------------
// mfd_out_if
// Result channel out of the deframer: payload bytes and frame status.
// ----------------------------------------------------------------------------
interface mfd_out_if import mfd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  frame_status;
  logic [15:0] frame_length;
  logic [7:0]  control_value;
  logic [7:0]  address_value;
  logic        is_last;

  modport source (output valid, output result_kind, output payload_byte,
                  output frame_status, output frame_length, output control_value,
                  output address_value, output is_last, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input frame_status, input frame_length, input control_value,
                  input address_value, input is_last, output ready);
endinterface

// File: rtl/mfd_cfg_if.sv
// ----------------------------------------------------------------------------
// mfd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mfd_cfg_if import mfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/mfd_front.sv
// ----------------------------------------------------------------------------
// mfd_front
// Frame parser: tracks the byte position, runs the CRC, checks the fields
// and writes the results of each byte, if it has any, into the queue.
// ----------------------------------------------------------------------------
module mfd_front import mfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  mfd_in_if.sink   rx,
  mfd_cfg_if.sink  cfg,
  input  logic     q_full,
  output mfd_qwr_t q_wr
);

  localparam logic [2:0] P_LEN_LO = 3'd2;
  localparam logic [2:0] P_LEN_HI = 3'd3;
  localparam logic [2:0] P_CTRL   = 3'd4;
  localparam logic [2:0] P_ADDR   = 3'd5;
  localparam logic [2:0] P_HCS_LO = 3'd6;

  logic [7:0]       start_byte, end_byte;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      length_reg, length_reg_next;
  logic [7:0]       control_reg, control_reg_next;
  logic [7:0]       address_reg, address_reg_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [15:0]      header_crc_calc, header_crc_calc_next;
  logic [15:0]      received_check, received_check_next;
  logic [3:0]       error_flags, error_flags_next;
  logic             frame_done, frame_done_next;

  logic             accept;
  logic [7:0]       b;
  logic [15:0]      crc_upd;
  logic [POS_W-1:0] pay_end;
  logic [15:0]      check_hi;
  mfd_entry_t       entry;

  assign rx.ready  = !q_full;
  assign cfg.ready = 1'b1;
  assign accept    = rx.valid && !q_full;
  assign b         = rx.rx_byte;
  assign crc_upd   = crc_byte(running_crc, b);
  assign pay_end   = POS_W'(PAYLOAD_START) + POS_W'(length_reg);
  assign check_hi  = {b, received_check[7:0]};

  always_comb begin
    byte_position_next   = byte_position;
    length_reg_next      = length_reg;
    control_reg_next     = control_reg;
    address_reg_next     = address_reg;
    running_crc_next     = running_crc;
    header_crc_calc_next = header_crc_calc;
    received_check_next  = received_check;
    error_flags_next     = error_flags;
    frame_done_next      = frame_done;
    entry                = '0;

    if (!frame_done) begin
      priority if (byte_position <= POS_W'(1)) begin
        if (b != start_byte) error_flags_next[ERR_START] = 1'b1;
      end else if (byte_position <= POS_W'(PAYLOAD_START - 1)) begin
        unique case (byte_position[2:0])
          P_LEN_LO: length_reg_next     = {8'h00, b};
          P_LEN_HI: length_reg_next     = {b, length_reg[7:0]};
          P_CTRL:   control_reg_next    = b;
          P_ADDR:   address_reg_next    = b;
          P_HCS_LO: received_check_next = {8'h00, b};
          default: begin
            received_check_next = check_hi;
            if (check_hi != header_crc_calc) error_flags_next[ERR_HCS] = 1'b1;
          end
        endcase
        running_crc_next = crc_upd;
        if (byte_position[2:0] == P_ADDR) header_crc_calc_next = crc_upd;
      end else if (byte_position < pay_end) begin
        running_crc_next = crc_upd;
        if (error_flags[ERR_HCS:ERR_START] == 2'b00) begin
          entry.pay_v    = 1'b1;
          entry.pay_byte = b;
        end
      end else if (byte_position == pay_end) begin
        received_check_next = {8'h00, b};
      end else if (byte_position == pay_end + POS_W'(1)) begin
        received_check_next = check_hi;
        if (check_hi != running_crc) error_flags_next[ERR_FCS] = 1'b1;
      end else begin
        if (b != end_byte) error_flags_next[ERR_END] = 1'b1;
        frame_done_next = 1'b1;
      end
      if (byte_position != POS_MAX) byte_position_next = byte_position + POS_W'(1);
    end

    entry.length  = length_reg_next;
    entry.control = control_reg_next;
    entry.address = address_reg_next;

    if (rx.buffer_end) begin
      entry.stat_v = 1'b1;
      priority if (!frame_done_next || error_flags_next[ERR_START]) entry.status = ST_FRAME;
      else if (error_flags_next[ERR_HCS]) entry.status = ST_HCS;
      else if (error_flags_next[ERR_FCS]) entry.status = ST_FCS;
      else if (error_flags_next[ERR_END]) entry.status = ST_END;
      else entry.status = ST_OK;
      byte_position_next   = '0;
      length_reg_next      = '0;
      control_reg_next     = '0;
      address_reg_next     = '0;
      running_crc_next     = CRC_INIT;
      header_crc_calc_next = '0;
      received_check_next  = '0;
      error_flags_next     = '0;
      frame_done_next      = 1'b0;
    end
  end

  assign q_wr.push  = accept && (entry.pay_v || entry.stat_v);
  assign q_wr.entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte      <= START_BYTE_RST;
      end_byte        <= END_BYTE_RST;
      byte_position   <= '0;
      length_reg      <= '0;
      control_reg     <= '0;
      address_reg     <= '0;
      running_crc     <= CRC_INIT;
      header_crc_calc <= '0;
      received_check  <= '0;
      error_flags     <= '0;
      frame_done      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_START_BYTE: start_byte <= cfg.data;
          CFG_END_BYTE:   end_byte   <= cfg.data;
          default:        start_byte <= start_byte;
        endcase
      end
      if (accept) begin
        byte_position   <= byte_position_next;
        length_reg      <= length_reg_next;
        control_reg     <= control_reg_next;
        address_reg     <= address_reg_next;
        running_crc     <= running_crc_next;
        header_crc_calc <= header_crc_calc_next;
        received_check  <= received_check_next;
        error_flags     <= error_flags_next;
        frame_done      <= frame_done_next;
      end
    end
  end

endmodule

// File: rtl/mfd_queue.sv
// ----------------------------------------------------------------------------
// mfd_queue
// Four-entry queue that decouples the parser from the result sequencer.
// ----------------------------------------------------------------------------
module mfd_queue import mfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mfd_qwr_t q_wr,
  input  logic     pop,
  output mfd_qrd_t q_rd
);

  mfd_entry_t     entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           do_pop;

  assign q_rd.empty = (count == '0);
  assign q_rd.full  = (count == (QAW+1)'(QDEPTH));
  assign q_rd.entry = entries[rd_ptr];
  assign do_pop     = pop && !q_rd.empty;

  always_ff @(posedge clk) begin
    if (q_wr.push) entries[wr_ptr] <= q_wr.entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) wr_ptr <= wr_ptr + QAW'(1);
      if (do_pop)    rd_ptr <= rd_ptr + QAW'(1);
      count <= count + (QAW+1)'(q_wr.push) - (QAW+1)'(do_pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_wr.push && q_rd.full))
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_head_has_result: assert property (@(posedge clk) disable iff (rst)
    !q_rd.empty |-> (q_rd.entry.pay_v || q_rd.entry.stat_v))
    else $error("queue entry carries no result");

endmodule

// File: rtl/mfd_back.sv
// ----------------------------------------------------------------------------
// mfd_back
// Result sequencer: turns queue entries into one or two results and holds
// them in the output register.
// ----------------------------------------------------------------------------
module mfd_back import mfd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mfd_qrd_t q_rd,
  output logic     pop,
  mfd_out_if.source tx
);

  logic sent_pay;
  logic load;
  logic split;

  assign load  = !tx.valid || tx.ready;
  // An entry with both a payload byte and a status goes out in two steps.
  assign split = q_rd.entry.pay_v && q_rd.entry.stat_v && !sent_pay;
  assign pop   = load && !q_rd.empty && !split;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
      sent_pay <= 1'b0;
    end else if (load) begin
      tx.valid <= !q_rd.empty;
      if (!q_rd.empty) sent_pay <= split;
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_rd.empty) begin
      tx.frame_length  <= q_rd.entry.length;
      tx.control_value <= q_rd.entry.control;
      tx.address_value <= q_rd.entry.address;
      if (q_rd.entry.pay_v && !sent_pay) begin
        tx.result_kind  <= KIND_PAYLOAD;
        tx.payload_byte <= q_rd.entry.pay_byte;
        tx.frame_status <= ST_OK;
        tx.is_last      <= 1'b0;
      end else begin
        tx.result_kind  <= KIND_STATUS;
        tx.payload_byte <= 8'h00;
        tx.frame_status <= q_rd.entry.status;
        tx.is_last      <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/meter_frame_deframer_crc16.sv
// ----------------------------------------------------------------------------
// meter_frame_deframer_crc16
// Byte-serial frame checker with CRC-16 header and frame checks.
//
//   Channel  Direction  Transfer carries
//   rx       in         rx_byte, buffer_end
//   tx       out        result_kind, payload_byte, frame_status, frame_length,
//                       control_value, address_value, is_last
//   cfg      in         index (0 start byte, 1 end byte), data
//
// The block accepts one byte per cycle while the queue is not full. Each
// byte updates the parser in the cycle of its transfer; its results pass
// through the queue before they reach the output register. A payload byte
// that is also the buffer's last byte gives two results, which the back end
// delivers one after the other; the four-entry queue between the parser and
// the back end soaks that up. Reset (rst, synchronous) clears all parser state,
// empties the queue and restores start byte 0x68 and end byte 0x16. A stalled
// tx holds its result while rx keeps transferring until the queue fills.
// ----------------------------------------------------------------------------
module meter_frame_deframer_crc16 import mfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mfd_in_if.sink    rx,
  mfd_out_if.source tx,
  mfd_cfg_if.sink   cfg
);

  // Parser-to-queue write and queue status toward both sides.
  mfd_qwr_t q_wr;
  mfd_qrd_t q_rd;
  logic     pop;

  // The front end parses the frame: position tracking, field capture, the
  // CRC-16 update (one byte per cycle, unrolled) and the status decision
  // at the buffer's last byte. It stalls rx only when the queue is full.
  mfd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .cfg    (cfg),
    .q_full (q_rd.full),
    .q_wr   (q_wr)
  );

  // The queue holds the results of up to four bytes.
  mfd_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (pop),
    .q_rd (q_rd)
  );

  // The back end emits payload results before the status of the same byte.
  mfd_back u_back (
    .clk  (clk),
    .rst  (rst),
    .q_rd (q_rd),
    .pop  (pop),
    .tx   (tx)
  );

endmodule
